// ===== rtl/sadc_pkg.sv =====
// ----------------------------------------------------------------------------
// sadc_pkg
// shared types and constants of the servo axis drive controller: beat
// payloads, register file contents, stage records and fixed codes
// ----------------------------------------------------------------------------
`default_nettype none

package sadc_pkg;

    // potentiometer sample width
    localparam int POS_BITS     = 10;
    localparam int AXIS_W       = 3;
    localparam int GAIN_W       = 4;
    localparam int SPEED_W      = 7;
    localparam int DUTY_W       = 12;
    localparam int DIR_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;

    // intermediate widths
    localparam int SPEED_PROD_W = POS_BITS + GAIN_W;
    localparam int SCALED_W     = SPEED_W + DUTY_W;

    // divide by 100 through a reciprocal multiply; the estimate is low by at
    // most one and a single compare-subtract fixes it
    localparam int DIV_SHIFT    = 20;
    localparam int RECIP_W      = 14;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((1 << DIV_SHIFT) / 100);
    localparam int QUOT_W       = SCALED_W + RECIP_W - DIV_SHIFT;
    localparam int REM_W        = SCALED_W + 1;
    localparam logic [REM_W-1:0] PERCENT_FULL = REM_W'(100);
    localparam logic [QUOT_W-1:0] DUTY_MAX = QUOT_W'(4095);

    // axis numbers
    localparam logic [AXIS_W-1:0] AXIS_BASE     = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_SHOULDER = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_ELBOW    = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_HEAD     = 3'd4;

    // logical direction codes
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AXIS0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AXIS1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AXIS2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AXIS4     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FULL_SCALE = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_GAIN_AXIS0     = 4'd2;
    localparam logic [GAIN_W-1:0]  RST_GAIN_AXIS1     = 4'd2;
    localparam logic [GAIN_W-1:0]  RST_GAIN_AXIS2     = 4'd2;
    localparam logic [GAIN_W-1:0]  RST_GAIN_AXIS4     = 4'd1;
    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT    = 7'd100;
    localparam logic [DUTY_W-1:0]  RST_PWM_FULL_SCALE = 12'd2000;

    typedef struct packed {
        logic [AXIS_W-1:0]   axis;
        logic [POS_BITS-1:0] position;
        logic [POS_BITS-1:0] target;
    } req_item_t;

    typedef struct packed {
        logic [AXIS_W-1:0] axis_out;
        logic              active;
        logic              drive_enable;
        logic [DUTY_W-1:0] duty;
        logic [DIR_W-1:0]  direction_code;
        logic              pin_inverted;
    } rsp_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_axis0;
        logic [GAIN_W-1:0]  gain_axis1;
        logic [GAIN_W-1:0]  gain_axis2;
        logic [GAIN_W-1:0]  gain_axis4;
        logic [SPEED_W-1:0] speed_limit;
        logic [DUTY_W-1:0]  pwm_full_scale;
    } cfg_t;

    // axis attributes that ride along with every stage
    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic              active;
        logic              inv;
        logic [DIR_W-1:0]  dir;
    } tag_t;

    typedef struct packed {
        tag_t                tag;
        logic [POS_BITS-1:0] mag;
        logic [GAIN_W-1:0]   gain;
    } err_rec_t;

    typedef struct packed {
        tag_t               tag;
        logic [SPEED_W-1:0] speed;
    } speed_rec_t;

    typedef struct packed {
        tag_t                tag;
        logic [SPEED_W-1:0]  speed;
        logic [SCALED_W-1:0] scaled;
    } scaled_rec_t;

    typedef struct packed {
        tag_t                tag;
        logic [SPEED_W-1:0]  speed;
        logic [SCALED_W-1:0] scaled;
        logic [QUOT_W-1:0]   quot_est;
    } quot_rec_t;

endpackage

`default_nettype wire

// ===== rtl/sadc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sadc_cfg_regs
// register file for axis gains, speed ceiling and pwm full scale
// ----------------------------------------------------------------------------
`default_nettype none

module sadc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sadc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sadc_pkg::CFG_DATA_W-1:0] cfg_data,
    output sadc_pkg::cfg_t                      cfg
);
    import sadc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_AXIS0:     cfg_next.gain_axis0     = cfg_data[GAIN_W-1:0];
                REG_GAIN_AXIS1:     cfg_next.gain_axis1     = cfg_data[GAIN_W-1:0];
                REG_GAIN_AXIS2:     cfg_next.gain_axis2     = cfg_data[GAIN_W-1:0];
                REG_GAIN_AXIS4:     cfg_next.gain_axis4     = cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT:    cfg_next.speed_limit    = cfg_data[SPEED_W-1:0];
                REG_PWM_FULL_SCALE: cfg_next.pwm_full_scale = cfg_data[DUTY_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_axis0     <= RST_GAIN_AXIS0;
            cfg_reg.gain_axis1     <= RST_GAIN_AXIS1;
            cfg_reg.gain_axis2     <= RST_GAIN_AXIS2;
            cfg_reg.gain_axis4     <= RST_GAIN_AXIS4;
            cfg_reg.speed_limit    <= RST_SPEED_LIMIT;
            cfg_reg.pwm_full_scale <= RST_PWM_FULL_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sadc_front.sv =====
// ----------------------------------------------------------------------------
// sadc_front
// stages 1 and 2: error, direction and gain select, then saturated speed
// ----------------------------------------------------------------------------
`default_nettype none

module sadc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sadc_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sadc_pkg::req_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sadc_pkg::speed_rec_t      out_rec
);
    import sadc_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    err_rec_t   s1_reg;
    err_rec_t   s1_next;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    speed_rec_t s2_reg;
    speed_rec_t s2_next;

    logic                    s1_ready;
    logic                    s2_ready;
    logic                    pos_err;
    logic                    neg_err;
    logic [SPEED_PROD_W-1:0] speed_prod;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: error magnitude, direction, gain
    assign pos_err = in_item.position > in_item.target;
    assign neg_err = in_item.position < in_item.target;

    always_comb
    begin
        s1_next            = s1_reg;
        s1_valid_next      = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next      = in_valid;
            s1_next.tag.axis   = in_item.axis;
            s1_next.tag.active = 1'b1;
            s1_next.tag.inv    = 1'b0;
            s1_next.mag        = pos_err ? in_item.position - in_item.target
                                         : in_item.target - in_item.position;
            case (in_item.axis)
                AXIS_BASE:
                begin
                    s1_next.gain    = cfg.gain_axis0;
                    s1_next.tag.dir = pos_err ? DIR_CCW : DIR_CW;
                end
                AXIS_SHOULDER:
                begin
                    s1_next.gain    = cfg.gain_axis1;
                    s1_next.tag.dir = neg_err ? DIR_DOWN : DIR_UP;
                end
                AXIS_ELBOW:
                begin
                    s1_next.gain    = cfg.gain_axis2;
                    s1_next.tag.dir = pos_err ? DIR_DOWN : DIR_UP;
                    s1_next.tag.inv = 1'b1;
                end
                AXIS_HEAD:
                begin
                    s1_next.gain    = cfg.gain_axis4;
                    s1_next.tag.dir = pos_err ? DIR_DOWN : DIR_UP;
                    s1_next.tag.inv = 1'b1;
                end
                default:
                begin
                    s1_next.gain       = '0;
                    s1_next.tag.dir    = DIR_CW;
                    s1_next.tag.active = 1'b0;
                end
            endcase
        end
    end

    // stage 2: speed = |error| * gain, clipped at the ceiling; zero for an inactive axis
    assign speed_prod = SPEED_PROD_W'(s1_reg.mag) * SPEED_PROD_W'(s1_reg.gain);

    always_comb
    begin
        s2_next       = s2_reg;
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
            s2_next.tag   = s1_reg.tag;
            if (!s1_reg.tag.active)
                s2_next.speed = '0;
            else if (speed_prod > SPEED_PROD_W'(cfg.speed_limit))
                s2_next.speed = cfg.speed_limit;
            else
                s2_next.speed = speed_prod[SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_rec   = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/sadc_duty.sv =====
// ----------------------------------------------------------------------------
// sadc_duty
// stages 3 to 5: speed times full scale, divide by 100, output register
// ----------------------------------------------------------------------------
`default_nettype none

module sadc_duty (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sadc_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sadc_pkg::speed_rec_t in_rec,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output sadc_pkg::rsp_item_t       out_item
);
    import sadc_pkg::*;

    logic        s3_valid_reg;
    logic        s3_valid_next;
    scaled_rec_t s3_reg;
    scaled_rec_t s3_next;
    logic        s4_valid_reg;
    logic        s4_valid_next;
    quot_rec_t   s4_reg;
    quot_rec_t   s4_next;
    logic        s5_valid_reg;
    logic        s5_valid_next;
    rsp_item_t   s5_reg;
    rsp_item_t   s5_next;

    logic                          s3_ready;
    logic                          s4_ready;
    logic                          s5_ready;
    logic [SCALED_W+RECIP_W-1:0]   recip_prod;
    logic [REM_W-1:0]              quot_x100;
    logic [REM_W-1:0]              rem;
    logic [QUOT_W-1:0]             quot;

    assign s5_ready = !s5_valid_reg || !out_stall;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    // stage 3: speed * full scale
    always_comb
    begin
        s3_next       = s3_reg;
        s3_valid_next = s3_valid_reg;
        if (s3_ready)
        begin
            s3_valid_next  = in_valid;
            s3_next.tag    = in_rec.tag;
            s3_next.speed  = in_rec.speed;
            s3_next.scaled = SCALED_W'(in_rec.speed) * SCALED_W'(cfg.pwm_full_scale);
        end
    end

    // stage 4: quotient estimate by reciprocal
    assign recip_prod = (SCALED_W+RECIP_W)'(s3_reg.scaled)
                      * (SCALED_W+RECIP_W)'(DIV_RECIP);

    always_comb
    begin
        s4_next       = s4_reg;
        s4_valid_next = s4_valid_reg;
        if (s4_ready)
        begin
            s4_valid_next    = s3_valid_reg;
            s4_next.tag      = s3_reg.tag;
            s4_next.speed    = s3_reg.speed;
            s4_next.scaled   = s3_reg.scaled;
            s4_next.quot_est = recip_prod[SCALED_W+RECIP_W-1:DIV_SHIFT];
        end
    end

    // stage 5: fix the estimate, clip, pick the duty source
    assign quot_x100 = (REM_W'(s4_reg.quot_est) << 6) + (REM_W'(s4_reg.quot_est) << 5)
                     + (REM_W'(s4_reg.quot_est) << 2);
    assign rem       = REM_W'(s4_reg.scaled) - quot_x100;
    assign quot      = (rem >= PERCENT_FULL) ? s4_reg.quot_est + 1'b1 : s4_reg.quot_est;

    always_comb
    begin
        s5_next       = s5_reg;
        s5_valid_next = s5_valid_reg;
        if (s5_ready)
        begin
            s5_valid_next          = s4_valid_reg;
            s5_next.axis_out       = s4_reg.tag.axis;
            s5_next.active         = s4_reg.tag.active;
            s5_next.direction_code = s4_reg.tag.dir;
            s5_next.pin_inverted   = s4_reg.tag.inv;
            s5_next.drive_enable   = (s4_reg.speed != '0);
            if (s4_reg.tag.axis == AXIS_HEAD)
                s5_next.duty = DUTY_W'(s4_reg.speed);
            else if (quot > DUTY_MAX)
                s5_next.duty = DUTY_MAX[DUTY_W-1:0];
            else
                s5_next.duty = quot[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
        s4_reg <= s4_next;
        s5_reg <= s5_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_item  = s5_reg;

endmodule

`default_nettype wire

// ===== rtl/servo_axis_drive_controller.sv =====
// ----------------------------------------------------------------------------
// servo_axis_drive_controller
// proportional position controller for four servo axes: error, clipped
// speed, pwm duty, drive enable and direction for every sample beat
// ----------------------------------------------------------------------------
//
//  channel | signals                         | direction | beat
//  --------+---------------------------------+-----------+---------------------
//  req     | req_valid req_stall req_data    | in        | axis, sample, target
//  rsp     | rsp_valid rsp_stall rsp_data    | out       | one result per req
//  cfg     | cfg_valid cfg_ready cfg_index   | in        | register write
//          | cfg_data                        |           |
//
//  five register stages, one beat per cycle while rsp_stall is low
//  the divide by 100 is a reciprocal multiply in stage 4 with a one-step
//  fix in stage 5; each multiply sits in a stage of its own
//  reset clears all stage valid bits and loads the register defaults
//  a stalled result holds in the output register; empty stages still fill
//  behind it, and req_stall rises only once every stage is occupied
//
`default_nettype none

module servo_axis_drive_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire sadc_pkg::req_item_t             req_data,
    // result channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output sadc_pkg::rsp_item_t                  rsp_data,
    // register write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sadc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sadc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sadc_pkg::*;

    cfg_t       cfg;
    logic       front_ready;
    logic       mid_valid;
    logic       mid_ready;
    speed_rec_t mid_rec;

    // gains, speed ceiling, full scale
    sadc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stages 1-2: error and saturated speed
    sadc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (req_valid),
        .in_ready  (front_ready),
        .in_item   (req_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_rec   (mid_rec)
    );

    // stages 3-5: duty scaling and output register
    sadc_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_rec    (mid_rec),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_item  (rsp_data)
    );

    assign req_stall = !front_ready;

endmodule

`default_nettype wire
